>>> hdl/hoar_pkg.sv
package hoar_pkg;

    // Frame geometry and sample format
    localparam int FRAME_SIZE         = 32;
    localparam int HALF               = FRAME_SIZE / 2;
    localparam int SAMPLE_BITS        = 16;
    localparam int HOAR_BUFFER_DEPTH  = 128;
    localparam int QUEUE_DEPTH        = 2;

    // Datapath widths
    localparam int TAP_W  = $clog2(FRAME_SIZE);
    localparam int WIN_W  = 17;
    localparam int W2_W   = 31;
    localparam int VAL_W  = 40;
    localparam int WT_W   = 32;
    localparam int PROD_W = 48;
    localparam int DIVN_W = 56;

    localparam longint unsigned PI_Q30   = 64'd3373259426;
    localparam longint unsigned ONE_Q30  = 64'd1 << 30;
    localparam longint unsigned WIN_SPAN = 2 * HALF;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_READ = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FRD,
        S_FMUL,
        S_FWR,
        S_RWAIT,
        S_RDIV
    } t_bstate;

    typedef struct packed {
        logic                          cmd;
        logic signed [SAMPLE_BITS-1:0] sample_in;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        t_status                       status;
        logic                          frame_done;
    } t_out_item;

    typedef struct packed {
        t_op                           op;
        logic signed [SAMPLE_BITS-1:0] sample;
    } t_cmd;

    typedef logic [WIN_W-1:0] t_win_tab [FRAME_SIZE];

    // Q2.30 cosine by truncated Taylor series, clamped to [0,1]
    function automatic longint unsigned cos_q30(input longint unsigned y);
        longint unsigned y2;
        longint unsigned term;
        longint          sum;
        y2   = (y * y) >> 30;
        term = ONE_Q30;
        sum  = longint'(ONE_Q30);
        term = ((term * y2) >> 30) >> 1;      sum = sum - longint'(term);
        term = ((term * y2) >> 30) / 64'd12;  sum = sum + longint'(term);
        term = ((term * y2) >> 30) / 64'd30;  sum = sum - longint'(term);
        term = ((term * y2) >> 30) / 64'd56;  sum = sum + longint'(term);
        term = ((term * y2) >> 30) / 64'd90;  sum = sum - longint'(term);
        term = ((term * y2) >> 30) / 64'd132; sum = sum + longint'(term);
        term = ((term * y2) >> 30) / 64'd182; sum = sum - longint'(term);
        term = ((term * y2) >> 30) / 64'd240; sum = sum + longint'(term);
        if (sum < 0) sum = 0;
        if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
        return longint'(sum);
    endfunction

    // Hann window table, unsigned Q1.15
    function automatic t_win_tab build_win();
        t_win_tab        tab;
        longint          k;
        longint unsigned ak;
        longint unsigned y;
        longint unsigned c;
        for (int i = 0; i < FRAME_SIZE; i++) begin
            k   = longint'(i) - longint'(HALF);
            ak  = (k < 0) ? longint'(-k) : longint'(k);
            y   = (PI_Q30 * ak) / WIN_SPAN;
            c   = cos_q30(y);
            tab[i] = WIN_W'((c * c + (64'd1 << 44)) >> 45);
        end
        return tab;
    endfunction

    localparam t_win_tab WIN_ROM = build_win();

endpackage

>>> hdl/hoar_front.sv
module hoar_front import hoar_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in,
    input  logic     i_hold,
    output logic     o_q_valid,
    input  logic     i_q_ready,
    output t_cmd     o_q_item
);

    localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    t_cmd           r_q [QUEUE_DEPTH];
    logic [QPW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCW-1:0] r_count,  n_count;
    logic           push, pop;
    t_cmd           cls_item;

    // classify the incoming item
    always_comb begin
        cls_item.op     = i_in.cmd ? OP_READ : OP_PUSH;
        cls_item.sample = i_in.sample_in;
    end

    assign o_in_ready = (r_count != QCW'(QUEUE_DEPTH)) && !i_hold;
    assign o_q_valid  = (r_count != '0);
    assign o_q_item   = r_q[r_rd_ptr];
    assign push       = i_in_valid && o_in_ready;
    assign pop        = o_q_valid && i_q_ready;

    // advance pointers and count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) n_count = r_count + 1'b1;
        else if (pop && !push) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // store the item
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr_ptr] <= cls_item;
    end

endmodule

>>> hdl/hoar_div.sv
module hoar_div import hoar_pkg::*; #(
    parameter int NW = DIVN_W,
    parameter int DW = WT_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);

    localparam int CNW = $clog2(NW + 1);

    logic [DW-1:0]  r_rem;
    logic [NW-1:0]  r_quo;
    logic [DW-1:0]  r_div;
    logic [CNW-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [DW:0]    rem_sh;
    logic [DW:0]    rem_sub;
    logic           take;

    // one restoring step per cycle
    always_comb begin
        rem_sh  = {r_rem, r_quo[NW-1]};
        rem_sub = rem_sh - {1'b0, r_div};
        take    = (rem_sh >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= take ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            r_quo <= {r_quo[NW-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

>>> hdl/hoar_back.sv
module hoar_back import hoar_pkg::*; #(
    parameter int BUFFER_DEPTH = HOAR_BUFFER_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    output logic      o_q_ready,
    input  t_cmd      i_q_item,
    output logic      o_clearing,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int PW = CW + 2;
    localparam logic [AW:0] DEPTH_X  = (AW + 1)'(BUFFER_DEPTH);
    localparam logic [AW-1:0] CLR_LAST = AW'(2 * FRAME_SIZE - 1);

    function automatic logic [AW-1:0] wrap_add(input logic [AW:0] a, input logic [AW:0] b);
        logic [AW:0] s;
        s = a + b;
        if (s >= DEPTH_X) s = s - DEPTH_X;
        return s[AW-1:0];
    endfunction

    // rings
    logic signed [SAMPLE_BITS-1:0] m_in  [BUFFER_DEPTH];
    logic signed [VAL_W-1:0]       m_val [BUFFER_DEPTH];
    logic [WT_W-1:0]               m_wt  [BUFFER_DEPTH];

    t_bstate                       r_state, n_state;
    logic [AW-1:0]                 r_in_head, n_in_head;
    logic [CW-1:0]                 r_in_count, n_in_count;
    logic [AW-1:0]                 r_out_head, n_out_head;
    logic [CW-1:0]                 r_out_count, n_out_count;
    logic [TAP_W-1:0]              r_tap, n_tap;
    logic [AW-1:0]                 r_clr_idx, n_clr_idx;
    logic [AW-1:0]                 r_tgt_idx, n_tgt_idx;
    logic                          r_tgt_keep, n_tgt_keep;
    logic [W2_W-1:0]               r_w2, n_w2;
    logic signed [PROD_W-1:0]      r_prod;
    logic                          r_neg, n_neg;
    logic                          r_out_valid, n_out_valid;
    t_out_item                     r_out, n_out;
    logic signed [SAMPLE_BITS-1:0] r_in_rd;
    logic signed [VAL_W-1:0]       r_val_rd;
    logic [WT_W-1:0]               r_wt_rd;

    logic                          in_we;
    logic [AW-1:0]                 in_waddr;
    logic [AW-1:0]                 in_raddr;
    logic                          in_re;
    logic                          ring_we;
    logic [AW-1:0]                 ring_waddr;
    logic signed [VAL_W-1:0]       val_wdata;
    logic [WT_W-1:0]               wt_wdata;
    logic                          ring_re;
    logic [AW-1:0]                 ring_raddr;
    logic                          div_start;
    logic [DIVN_W-1:0]             div_dividend;
    logic                          div_done;
    logic [DIVN_W-1:0]             div_quot;

    logic                          tap_first;
    logic [PW-1:0]                 pos;
    logic [2*WIN_W-1:0]            w_sq;
    logic [CW:0]                   in_inc;
    logic [CW:0]                   oc_plus;
    logic                          refuse;
    logic signed [PROD_W-1:0]      rnd;
    logic signed [PROD_W-1:0]      contrib;
    logic [VAL_W-1:0]              v_abs;
    logic signed [SAMPLE_BITS-1:0] sat;

    // tap and ring arithmetic
    always_comb begin
        tap_first = (r_tap < TAP_W'(HALF));
        pos       = PW'(r_out_count) - PW'(HALF) + PW'(r_tap);
        w_sq      = {{WIN_W{1'b0}}, WIN_ROM[r_tap]} * {{WIN_W{1'b0}}, WIN_ROM[r_tap]};
        in_inc    = {1'b0, r_in_count} + 1'b1;
        oc_plus   = {1'b0, r_out_count} + (CW + 1)'(HALF);
        refuse    = ({1'b0, r_in_count} >= (CW + 1)'(BUFFER_DEPTH)) ||
                    ((in_inc >= (CW + 1)'(FRAME_SIZE)) &&
                     (oc_plus > (CW + 1)'(BUFFER_DEPTH)));
        rnd       = r_prod + PROD_W'(16384);
        contrib   = rnd >>> 15;
        v_abs     = r_val_rd[VAL_W-1] ? VAL_W'(-r_val_rd) : VAL_W'(r_val_rd);
        div_dividend = {1'b0, v_abs, 15'b0} + DIVN_W'(r_wt_rd >> 1);
        if (r_neg) begin
            sat = (div_quot > DIVN_W'(32768)) ? SAMPLE_BITS'(-32768)
                                              : SAMPLE_BITS'(-div_quot[SAMPLE_BITS-1:0]);
        end else begin
            sat = (div_quot > DIVN_W'(32767)) ? SAMPLE_BITS'(32767)
                                              : SAMPLE_BITS'(div_quot[SAMPLE_BITS-1:0]);
        end
    end

    assign o_q_ready  = (r_state == S_IDLE) && !r_out_valid;
    assign o_clearing = (r_state == S_CLEAR);

    // sequence items: pushes, frame passes, reads
    always_comb begin
        n_state     = r_state;
        n_in_head   = r_in_head;
        n_in_count  = r_in_count;
        n_out_head  = r_out_head;
        n_out_count = r_out_count;
        n_tap       = r_tap;
        n_clr_idx   = r_clr_idx;
        n_tgt_idx   = r_tgt_idx;
        n_tgt_keep  = r_tgt_keep;
        n_w2        = r_w2;
        n_neg       = r_neg;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        in_we       = 1'b0;
        in_waddr    = wrap_add({1'b0, r_in_head}, (AW + 1)'(r_in_count));
        in_re       = 1'b0;
        in_raddr    = wrap_add({1'b0, r_in_head}, (AW + 1)'(r_tap));
        ring_we     = 1'b0;
        ring_waddr  = r_tgt_idx;
        val_wdata   = tap_first ? r_val_rd + contrib[VAL_W-1:0] : contrib[VAL_W-1:0];
        wt_wdata    = tap_first ? r_wt_rd + WT_W'(r_w2) : WT_W'(r_w2);
        ring_re     = 1'b0;
        ring_raddr  = r_out_head;
        div_start   = 1'b0;
        case (r_state)
            S_CLEAR: begin
                // seed the first two frames with zero value and unit weight
                ring_we    = 1'b1;
                ring_waddr = r_clr_idx;
                val_wdata  = '0;
                wt_wdata   = WT_W'(ONE_Q30);
                n_clr_idx  = r_clr_idx + 1'b1;
                if (r_clr_idx == CLR_LAST) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_q_valid && !r_out_valid) begin
                    n_out.sample_out = '0;
                    n_out.status     = STAT_OK;
                    n_out.frame_done = 1'b0;
                    if (i_q_item.op == OP_READ) begin
                        if (r_out_count == '0) begin
                            n_out.status = STAT_EMPTY;
                            n_out_valid  = 1'b1;
                        end else begin
                            ring_re     = 1'b1;
                            n_out_head  = wrap_add({1'b0, r_out_head}, (AW + 1)'(1));
                            n_out_count = r_out_count - 1'b1;
                            n_state     = S_RWAIT;
                        end
                    end else if (refuse) begin
                        n_out.status = STAT_FULL;
                        n_out_valid  = 1'b1;
                    end else begin
                        in_we      = 1'b1;
                        n_in_count = in_inc[CW-1:0];
                        if (in_inc >= (CW + 1)'(FRAME_SIZE)) begin
                            n_tap   = '0;
                            n_state = S_FRD;
                        end else begin
                            n_out_valid = 1'b1;
                        end
                    end
                end
            end
            S_FRD: begin
                // fetch sample and target entry, square the window tap
                in_re = 1'b1;
                n_w2  = w_sq[W2_W-1:0];
                if (tap_first) begin
                    n_tgt_keep = !pos[PW-1];
                    n_tgt_idx  = wrap_add({1'b0, r_out_head}, pos[AW:0]);
                end else begin
                    n_tgt_keep = 1'b1;
                    n_tgt_idx  = wrap_add({1'b0, r_out_head}, (AW + 1)'(r_out_count));
                end
                ring_re    = 1'b1;
                ring_raddr = n_tgt_idx;
                n_state    = S_FMUL;
            end
            S_FMUL: begin
                n_state = S_FWR;
            end
            S_FWR: begin
                // accumulate or append, then advance the tap
                ring_we = r_tgt_keep;
                if (!tap_first) n_out_count = r_out_count + 1'b1;
                n_tap = r_tap + 1'b1;
                if (r_tap == TAP_W'(FRAME_SIZE - 1)) begin
                    n_in_head        = wrap_add({1'b0, r_in_head}, (AW + 1)'(HALF));
                    n_in_count       = r_in_count - CW'(HALF);
                    n_out.frame_done = 1'b1;
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    n_state = S_FRD;
                end
            end
            S_RWAIT: begin
                if (r_wt_rd == '0) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    div_start = 1'b1;
                    n_neg     = r_val_rd[VAL_W-1];
                    n_state   = S_RDIV;
                end
            end
            S_RDIV: begin
                if (div_done) begin
                    n_out.sample_out = sat;
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_in_head   <= '0;
            r_in_count  <= '0;
            r_out_head  <= '0;
            r_out_count <= CW'(2 * FRAME_SIZE);
            r_tap       <= '0;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_head   <= n_in_head;
            r_in_count  <= n_in_count;
            r_out_head  <= n_out_head;
            r_out_count <= n_out_count;
            r_tap       <= n_tap;
            r_clr_idx   <= n_clr_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_tgt_idx  <= n_tgt_idx;
        r_tgt_keep <= n_tgt_keep;
        r_w2       <= n_w2;
        r_neg      <= n_neg;
        r_out      <= n_out;
        r_prod     <= r_in_rd * $signed({1'b0, r_w2});
    end

    // input ring
    always_ff @(posedge i_clk) begin
        if (in_we) m_in[in_waddr] <= i_q_item.sample;
        if (in_re) r_in_rd <= m_in[in_raddr];
    end

    // output value and weight rings
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            m_val[ring_waddr] <= val_wdata;
            m_wt[ring_waddr]  <= wt_wdata;
        end
        if (ring_re) begin
            r_val_rd <= m_val[ring_raddr];
            r_wt_rd  <= m_wt[ring_raddr];
        end
    end

    hoar_div #(
        .NW (DIVN_W),
        .DW (WT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_wt_rd),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> hdl/hann_overlap_add_resynth.sv
// Each item is carried to its result in turn: a plain push, a refused item or an empty read
// directly; a push that completes a frame through a read, multiply and write step per window
// tap; a read through a 56-step restoring divider, unless its weight sum is zero.
// The back takes one item at a time, and no new item until the last one's result is taken.
// Reset is synchronous, active low; after it, the first two frames of the rings are seeded
// with zero value and unit weight while input ready is held low.
module hann_overlap_add_resynth import hoar_pkg::*; #(
    parameter int BUFFER_DEPTH = HOAR_BUFFER_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    logic q_valid;
    logic q_ready;
    t_cmd q_item;
    logic clearing;

    hoar_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .i_hold     (clearing),
        .o_q_valid  (q_valid),
        .i_q_ready  (q_ready),
        .o_q_item   (q_item)
    );

    hoar_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_ready   (q_ready),
        .i_q_item    (q_item),
        .o_clearing  (clearing),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule
